// ===== rtl/core/hkb_pkg.sv =====
// Shared types and constants for the six-key keyboard report unit.
`timescale 1ns / 1ps
`default_nettype none

package hkb_pkg;

    localparam int unsigned REPORT_KEY_BYTES = 6;
    localparam int unsigned KEY_W            = 8;
    localparam int unsigned REPORT_W         = REPORT_KEY_BYTES * KEY_W;

    typedef enum logic [1:0] {
        ACT_PRESS       = 2'd0,
        ACT_RELEASE     = 2'd1,
        ACT_RELEASE_ALL = 2'd2,
        ACT_LOAD        = 2'd3
    } t_action;

    typedef struct packed {
        logic match;
        logic empty;
    } t_cmp_res;

endpackage

`default_nettype wire

// ===== rtl/core/hkb_cmp_unit.sv =====
// Shared slot comparator: matches one slot byte against the item's key code.
`timescale 1ns / 1ps
`default_nettype none

module hkb_cmp_unit
    import hkb_pkg::*;
(
    input  wire logic [KEY_W-1:0] i_slot,
    input  wire logic [KEY_W-1:0] i_code,
    output t_cmp_res              o_res
);

    always_comb begin
        o_res.match = (i_slot == i_code);
        o_res.empty = (i_slot == '0);
    end

endmodule

`default_nettype wire

// ===== rtl/core/hid_keyboard_six_key_report_unit.sv =====
// Top level of the six-key keyboard report unit: slot store and scan sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Keyboard report builder in HID boot style (six-key rollover).
// Input channel: drive the action and its fields with start high; the item is
// taken at the edge where start is high and busy is low. busy stays high while
// the sequencer works on the item.
// Result channel: o_valid pulses for one cycle with the modifier byte and the
// six key bytes (slot 0 in the low byte). The receiver cannot stall; results
// appear only while the item's link_up bit was set.
// Sequence: press and release walk the slots one per cycle through one shared
// comparator, then pass through the write state and the report state.
// Release-all and load go from acceptance straight to the write and report
// states. Items that change nothing (code zero, key already held, release of
// an absent key, load with link down) skip the write and report states.
// The result strobe shows in the cycle after the last busy cycle, and a new
// item may be accepted in that same cycle.
// Reset (synchronous, active low) empties all slots, clears the modifiers and
// returns the sequencer to idle with no strobe pending.
module hid_keyboard_six_key_report_unit
    import hkb_pkg::*;
#(
    parameter int unsigned KEY_SLOT_COUNT = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_action,
    input  wire logic [KEY_W-1:0]    i_key_code,
    input  wire logic [KEY_W-1:0]    i_modifier_bits,
    input  wire logic [REPORT_W-1:0] i_loaded_keys,
    input  wire logic                i_link_up,
    output logic                     o_valid,
    output logic [KEY_W-1:0]         o_report_modifiers,
    output logic [REPORT_W-1:0]      o_report_keys
);

    localparam int unsigned IDX_W = (KEY_SLOT_COUNT > 1) ? $clog2(KEY_SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOT_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [KEY_W-1:0]    r_slots [KEY_SLOT_COUNT];
    logic [KEY_W-1:0]    r_mods;

    // Latched item
    t_action             r_action;
    logic [KEY_W-1:0]    r_code;
    logic [KEY_W-1:0]    r_load_mods;
    logic [REPORT_W-1:0] r_load_keys;
    logic                r_link;

    // Scan progress
    logic [IDX_W-1:0]    r_idx;
    logic                r_empty_found;
    logic [IDX_W-1:0]    r_empty_idx;

    t_cmp_res            w_cmp;
    logic [REPORT_W-1:0] w_report;
    logic [KEY_W-1:0]    w_load_slots [KEY_SLOT_COUNT];
    logic                w_accept;
    t_action             w_action;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_action = t_action'(i_action);

    // One comparator, stepped across the slots by r_idx
    hkb_cmp_unit u_cmp (
        .i_slot (r_slots[r_idx]),
        .i_code (r_code),
        .o_res  (w_cmp)
    );

    // Report packing: slots past the store read as zero; load clears extra slots
    genvar g;
    generate
        for (g = 0; g < REPORT_KEY_BYTES; g++) begin : g_pack
            if (g < KEY_SLOT_COUNT) begin : g_have
                assign w_report[g*KEY_W +: KEY_W] = r_slots[g];
            end else begin : g_none
                assign w_report[g*KEY_W +: KEY_W] = '0;
            end
        end
        for (g = 0; g < KEY_SLOT_COUNT; g++) begin : g_load
            if (g < REPORT_KEY_BYTES) begin : g_byte
                assign w_load_slots[g] = r_load_keys[g*KEY_W +: KEY_W];
            end else begin : g_zero
                assign w_load_slots[g] = '0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_mods  <= '0;
            for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                r_slots[i] <= '0;
            end
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_action      <= w_action;
                        r_code        <= i_key_code;
                        r_load_mods   <= i_modifier_bits;
                        r_load_keys   <= i_loaded_keys;
                        r_link        <= i_link_up;
                        r_idx         <= '0;
                        r_empty_found <= 1'b0;
                        r_empty_idx   <= '0;
                        case (w_action)
                            ACT_PRESS, ACT_RELEASE: begin
                                // Code zero is the empty marker: drop the item
                                if (i_key_code != '0) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            ACT_RELEASE_ALL: begin
                                r_state <= S_WRITE;
                            end
                            ACT_LOAD: begin
                                if (i_link_up) begin
                                    r_state <= S_WRITE;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_cmp.match) begin
                        // Press of a held key is a no-op; release holds r_idx as the hit
                        r_state <= (r_action == ACT_RELEASE) ? S_WRITE : S_IDLE;
                    end else begin
                        if (w_cmp.empty && !r_empty_found) begin
                            r_empty_found <= 1'b1;
                            r_empty_idx   <= r_idx;
                        end
                        if (r_idx == LAST_IDX) begin
                            r_state <= (r_action == ACT_PRESS) ? S_WRITE : S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_WRITE: begin
                    case (r_action)
                        ACT_PRESS: begin
                            if (r_empty_found) begin
                                r_slots[r_empty_idx] <= r_code;
                            end else begin
                                // Overflow: drop slot 0, shift down, append in the last slot
                                for (int i = 0; i + 1 < KEY_SLOT_COUNT; i++) begin
                                    r_slots[i] <= r_slots[i+1];
                                end
                                r_slots[LAST_IDX] <= r_code;
                            end
                        end
                        ACT_RELEASE: begin
                            r_slots[r_idx] <= '0;
                        end
                        ACT_RELEASE_ALL: begin
                            r_mods <= '0;
                            for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                                r_slots[i] <= '0;
                            end
                        end
                        ACT_LOAD: begin
                            r_mods <= r_load_mods;
                            for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                                r_slots[i] <= w_load_slots[i];
                            end
                        end
                        default: begin
                            r_mods <= r_mods;
                        end
                    endcase
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // State is updated either way; report only with the link up
                    o_valid            <= r_link;
                    o_report_modifiers <= r_mods;
                    o_report_keys      <= w_report;
                    r_state            <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A report strobe only follows the report cycle
    a_valid_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EMIT))
        else $error("report strobe without a report cycle");

    // The scan index never runs past the last slot
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= LAST_IDX))
        else $error("scan index beyond slot store");

    // The report cycle always frees the block next
    a_emit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |=> !busy)
        else $error("block still busy after report cycle");

    // A load with the link down is dropped at once
    a_load_link_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_action == ACT_LOAD) && !i_link_up) |=> !busy)
        else $error("load with link down started work");

endmodule

`default_nettype wire
